FILE: design/ds3d_pkg.sv
// ----------------------------------------------------------------------------
// ds3d_pkg
// Types, constants and fixed-point helpers of the 3D diffusion stencil.
// ----------------------------------------------------------------------------
package ds3d_pkg;

  localparam int unsigned MaxWidth  = 64;
  localparam int unsigned MaxHeight = 64;
  localparam int unsigned MaxDepth  = 64;
  localparam int unsigned XW        = $clog2(MaxWidth);
  localparam int unsigned YW        = $clog2(MaxHeight);
  localparam int unsigned ZW        = $clog2(MaxDepth) + 1;
  localparam int unsigned PlaneSize = MaxWidth * MaxHeight;
  localparam int unsigned PIdxW     = XW + YW;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned SizeW     = 7;

  typedef enum logic [CfgIdxW-1:0] {
    REG_COEFF_X     = 3'd0,
    REG_COEFF_Y     = 3'd1,
    REG_COEFF_Z     = 3'd2,
    REG_GRID_WIDTH  = 3'd3,
    REG_GRID_HEIGHT = 3'd4,
    REG_GRID_DEPTH  = 3'd5
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ1,
    ST_READ2,
    ST_READ3,
    ST_MUL,
    ST_SUM,
    ST_BUF,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic signed [31:0] voxel_value;
    logic signed [31:0] corr_factor;
    logic signed [31:0] buffer_factor;
    logic signed [31:0] conv_frac;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] new_value;
    logic               last;
  } out_word_t;

  typedef struct packed {
    logic [CfgIdxW-1:0] index;
    logic [31:0]        data;
  } cfg_word_t;

  // weight Q2.30 times value Q8.24, rounded to Q8.24
  function automatic logic signed [33:0] mulq(input logic signed [63:0] p);
    logic signed [63:0] r;
    r = p + 64'sd536870912;
    return 34'(r >>> 30);
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [36:0] v);
    if (v > 37'sd2147483647) return 32'sh7fffffff;
    if (v < -37'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

endpackage

FILE: design/ds3d_if.sv
// ----------------------------------------------------------------------------
// ds3d_if
// Valid/ready channel carrying one word of a given type.
// ----------------------------------------------------------------------------
interface ds3d_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: design/diffusion_stencil_3d_step.sv
// ----------------------------------------------------------------------------
// diffusion_stencil_3d_step
// One explicit step of 7-point 3D diffusion over a raster-streamed grid.
// ----------------------------------------------------------------------------
// channel  dir  word        accepted at
// in_ch    in   in_word_t   valid & ready
// out_ch   out  out_word_t  valid & ready
// cfg_ch   in   cfg_word_t  valid & ready (always ready)
//
// Each voxel passes through three reads of the value plane pair (centre,
// back and four neighbours over two read ports), then products, sum,
// buffer product and write-back; a result word then moves into the output
// register. The next voxel is taken once the result word is in the output
// register, which holds while out_ch stalls. Reset clears position and
// coefficients and sets sizes to 64; planes stay unset.
// ----------------------------------------------------------------------------
module diffusion_stencil_3d_step
  import ds3d_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  ds3d_if.sink   in_ch,
  ds3d_if.source out_ch,
  ds3d_if.sink   cfg_ch
);

  logic signed [31:0] coeff_x_q, coeff_y_q, coeff_z_q;
  logic [SizeW-1:0]   gw_q, gh_q, gd_q;
  logic [XW:0]        w;
  logic [YW:0]        h;
  logic [ZW-1:0]      d;

  assign cfg_ch.ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coeff_x_q <= '0; coeff_y_q <= '0; coeff_z_q <= '0;
      gw_q <= SizeW'(64); gh_q <= SizeW'(64); gd_q <= SizeW'(64);
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.data.index)
        REG_COEFF_X:     coeff_x_q <= cfg_ch.data.data;
        REG_COEFF_Y:     coeff_y_q <= cfg_ch.data.data;
        REG_COEFF_Z:     coeff_z_q <= cfg_ch.data.data;
        REG_GRID_WIDTH:  gw_q <= cfg_ch.data.data[SizeW-1:0];
        REG_GRID_HEIGHT: gh_q <= cfg_ch.data.data[SizeW-1:0];
        REG_GRID_DEPTH:  gd_q <= cfg_ch.data.data[SizeW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (gw_q < SizeW'(3)) w = (XW+1)'(3);
    else if (gw_q > SizeW'(MaxWidth)) w = (XW+1)'(MaxWidth);
    else w = (XW+1)'(gw_q);
    if (gh_q < SizeW'(3)) h = (YW+1)'(3);
    else if (gh_q > SizeW'(MaxHeight)) h = (YW+1)'(MaxHeight);
    else h = (YW+1)'(gh_q);
    if (gd_q < SizeW'(2)) d = ZW'(2);
    else if (gd_q > SizeW'(MaxDepth)) d = ZW'(MaxDepth);
    else d = ZW'(gd_q);
  end

  // memories
  logic [31:0] mem_val [2*PlaneSize];
  logic [31:0] mem_cf  [PlaneSize];
  logic [31:0] mem_bf  [PlaneSize];

  state_e state_q, state_d;
  logic [XW-1:0] x_q;
  logic [YW-1:0] y_q;
  logic [ZW-1:0] z_q;
  logic signed [31:0] hlf_q;
  in_word_t      w_q;
  logic          emit_q, last_q;
  logic signed [31:0] cxl_q;
  logic signed [31:0] c_q, l_q, r_q, u_q, dn_q, b_q, cf_q, bf_q;
  logic [31:0]   rd_a_q, rd_b_q;
  logic signed [33:0] t_q [7];
  logic signed [31:0] dp_q;
  logic signed [33:0] tb_q;
  logic          tb_valid_q, ow_valid_q;
  logic          ow_load;
  out_word_t     ow_q;

  logic accept;
  // a finished word waiting on a full output register holds the input
  assign in_ch.ready = (state_q == ST_IDLE) && !tb_valid_q;
  assign accept = in_ch.valid && in_ch.ready;

  logic cur, prv;
  assign cur = ~z_q[0];
  assign prv = z_q[0];

  logic [PIdxW-1:0] ic, iu, idn, il, ir;
  assign ic  = {y_q, x_q};
  assign iu  = {y_q - YW'(1), x_q};
  assign idn = {y_q + YW'(1), x_q};
  assign il  = {y_q, x_q - XW'(1)};
  assign ir  = {y_q, x_q + XW'(1)};

  // two read ports on the value plane pair
  logic [PIdxW:0] ra, rb;
  always_comb begin
    ra = {cur, ic}; rb = {prv, ic};
    unique case (state_q)
      ST_READ1: begin ra = {cur, il}; rb = {cur, ir}; end
      ST_READ2: begin ra = {cur, iu}; rb = {cur, idn}; end
      default:  begin ra = {cur, ic}; rb = {prv, ic}; end
    endcase
  end

  always_ff @(posedge clk_i) begin
    rd_a_q <= mem_val[ra];
    rd_b_q <= mem_val[rb];
    if (state_q == ST_READ1) begin
      cf_q <= mem_cf[ic];
      bf_q <= mem_bf[ic];
    end
  end

  // write-back of the new voxel after all reads
  always_ff @(posedge clk_i) begin
    if (state_q == ST_OUT) begin
      mem_val[{z_q[0], ic}] <= w_q.voxel_value;
      mem_cf[ic] <= w_q.corr_factor;
      mem_bf[ic] <= w_q.buffer_factor;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (accept) state_d = ST_READ1;
      ST_READ1: state_d = ST_READ2;
      ST_READ2: state_d = ST_READ3;
      ST_READ3: state_d = ST_MUL;
      ST_MUL:   state_d = ST_SUM;
      ST_SUM:   state_d = ST_BUF;
      ST_BUF:   state_d = ST_OUT;
      ST_OUT:   state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  logic signed [32:0] cxl_sum;
  assign cxl_sum = 33'(coeff_x_q) + 33'(hlf_q);

  logic xin, emit_c;
  assign xin = ({1'b0, x_q} < w) && ({1'b0, y_q} < h);
  assign emit_c = (z_q >= ZW'(1)) && (z_q < d) && (y_q >= YW'(1))
               && ((YW+1)'(y_q) + (YW+1)'(1) < h) && xin;

  logic xend, yend;
  assign xend = (XW+1)'(x_q) + (XW+1)'(1) >= w;
  assign yend = (YW+1)'(y_q) + (YW+1)'(1) >= h;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      x_q <= '0; y_q <= '0; z_q <= '0; hlf_q <= '0;
      emit_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (accept) emit_q <= emit_c;
      if (state_q == ST_OUT) begin
        if (xend && yend) hlf_q <= w_q.conv_frac;
        if (xend) begin
          x_q <= '0;
          if (yend) begin
            y_q <= '0;
            z_q <= (ZW'(z_q + ZW'(1)) >= d) ? '0 : z_q + ZW'(1);
          end else y_q <= y_q + YW'(1);
        end else x_q <= x_q + XW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      w_q <= in_ch.data;
      cxl_q <= sat32(37'(cxl_sum));
      last_q <= ((XW+1)'(x_q) + (XW+1)'(1) == w) && ((YW+1)'(y_q) + (YW+1)'(2) == h)
             && (z_q + ZW'(1) == d);
    end
    // read data lands in the cycle after its address
    unique case (state_q)
      ST_READ1: begin
        c_q <= rd_a_q;
        b_q <= (z_q >= ZW'(2)) ? rd_b_q : '0;
      end
      ST_READ2: begin
        l_q <= (x_q != '0) ? rd_a_q : '0;
        r_q <= ((XW+1)'(x_q) + (XW+1)'(1) < w) ? rd_b_q : '0;
      end
      ST_READ3: begin
        u_q <= rd_a_q; dn_q <= rd_b_q;
      end
      default: ;
    endcase
    // products: each 32x32 into its own register
    if (state_q == ST_SUM) begin
      t_q[0] <= mulq(64'(cxl_q) * 64'(l_q));
      t_q[1] <= mulq(64'(coeff_x_q) * 64'(r_q));
      t_q[2] <= mulq(64'(coeff_y_q) * 64'(u_q));
      t_q[3] <= mulq(64'(coeff_y_q) * 64'(dn_q));
      t_q[4] <= mulq(64'(coeff_z_q) * 64'(w_q.voxel_value));
      t_q[5] <= mulq(64'(coeff_z_q) * 64'(b_q));
      t_q[6] <= mulq(64'(cf_q) * 64'(c_q));
    end
    if (state_q == ST_BUF) begin
      dp_q <= sat32(37'(t_q[0]) + 37'(t_q[1]) + 37'(t_q[2]) + 37'(t_q[3])
                  + 37'(t_q[4]) + 37'(t_q[5]) + 37'(t_q[6]));
    end
    if (state_q == ST_OUT) begin
      tb_q <= mulq(64'(dp_q) * 64'(bf_q));
    end
  end

  // finished word moves on once the output register is free
  assign ow_load = tb_valid_q && (!ow_valid_q || out_ch.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tb_valid_q <= 1'b0;
      ow_valid_q <= 1'b0;
    end else begin
      if ((state_q == ST_OUT) && emit_q) tb_valid_q <= 1'b1;
      else if (ow_load) tb_valid_q <= 1'b0;
      if (ow_load) ow_valid_q <= 1'b1;
      else if (out_ch.ready) ow_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ow_load) begin
      ow_q.new_value <= sat32(37'(c_q) + 37'(tb_q));
      ow_q.last <= last_q;
    end
  end

  assign out_ch.valid = ow_valid_q;
  assign out_ch.data  = ow_q;

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> !in_ch.ready) else $error("accept while busy");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ow_valid_q && !out_ch.ready) |=> ow_valid_q) else $error("result dropped");
  a_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE && accept) |=> (state_q == ST_READ1)) else $error("fsm");

endmodule

FILE: verif/tb_ds3d_if.sv
// ----------------------------------------------------------------------------
// tb_ds3d_if
// Testbench-side note: the channel interface itself lives with the design.
// This file holds the expected-update type used by the testbench scoreboard.
// ----------------------------------------------------------------------------
package tb_ds3d_pkg;
  import ds3d_pkg::*;

  // expected update of one voxel: new value and end-of-step flag
  typedef struct {
    logic signed [31:0] new_value;
    logic               last;
  } update_t;

endpackage

FILE: verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the 3D diffusion stencil: streams grids of varied
// size and weights, predicts each voxel update and compares every word out.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ds3d_pkg::*;
  import tb_ds3d_pkg::*;

  class update_board;
    update_t pending[$];
    int      errors;
    int      checked;
    int      lasts;

    bit [31:0] cx, cy, cz;
    bit [6:0]  gw, gh, gd;
    bit [31:0] vals[2][MaxHeight][MaxWidth];
    bit [31:0] corr[MaxHeight][MaxWidth];
    bit [31:0] buff[MaxHeight][MaxWidth];
    bit [31:0] held_frac;
    int unsigned px, py, pz;

    function void reset_state();
      cx = 0; cy = 0; cz = 0;
      gw = 64; gh = 64; gd = 64;
      held_frac = 0; px = 0; py = 0; pz = 0;
    endfunction

    function void write_reg(cfg_reg_e idx, bit [31:0] d);
      case (idx)
        REG_COEFF_X:     cx = d;
        REG_COEFF_Y:     cy = d;
        REG_COEFF_Z:     cz = d;
        REG_GRID_WIDTH:  gw = d[6:0];
        REG_GRID_HEIGHT: gh = d[6:0];
        REG_GRID_DEPTH:  gd = d[6:0];
        default: ;
      endcase
    endfunction

    static function longint sat(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    // Q2.30 weight times Q8.24 value, round half up to Q8.24
    static function longint wmul(longint w, longint v);
      return (w * v + (64'sd1 <<< 29)) >>> 30;
    endfunction

    static function longint sx(bit [31:0] u);
      return longint'($signed(u));
    endfunction

    static function int unsigned clampsz(int unsigned v, int unsigned lo, int unsigned hi);
      return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function longint at(int unsigned s, int unsigned y, int unsigned x);
      if (x >= MaxWidth || y >= MaxHeight) return 0;
      return sx(vals[s][y][x]);
    endfunction

    function void note_voxel(in_word_t w);
      int unsigned wd, ht, dp_, x, y, z, cur;
      longint c, l, r, u, dn, bk, cxl, dp, nv;
      update_t e;
      wd = clampsz(gw, 3, MaxWidth);
      ht = clampsz(gh, 3, MaxHeight);
      dp_ = clampsz(gd, 2, MaxDepth);
      x = px; y = py; z = pz;
      if (z >= 1 && z < dp_ && y >= 1 && y + 1 < ht && x < wd) begin
        cur = (z - 1) & 1;
        c  = at(cur, y, x);
        l  = x > 0 ? at(cur, y, x - 1) : 0;
        r  = x + 1 < wd ? at(cur, y, x + 1) : 0;
        u  = at(cur, y - 1, x);
        dn = at(cur, y + 1, x);
        bk = z >= 2 ? at(z & 1, y, x) : 0;
        cxl = sat(sx(cx) + sx(held_frac));
        dp = wmul(cxl, l) + wmul(sx(cx), r) + wmul(sx(cy), u) + wmul(sx(cy), dn)
           + wmul(sx(cz), sx(w.voxel_value)) + wmul(sx(cz), bk)
           + wmul(sx(corr[y][x]), c);
        dp = sat(dp);
        nv = sat(c + wmul(dp, sx(buff[y][x])));
        e.new_value = nv[31:0];
        e.last = (x + 1 == wd && y + 2 == ht && z + 1 == dp_);
        pending.push_back(e);
      end
      vals[z & 1][y][x] = w.voxel_value;
      corr[y][x] = w.corr_factor;
      buff[y][x] = w.buffer_factor;
      if (x + 1 >= wd && y + 1 >= ht) held_frac = w.conv_frac;
      if (x + 1 >= wd) begin
        px = 0;
        if (y + 1 >= ht) begin
          py = 0;
          pz = (z + 1 >= dp_) ? 0 : z + 1;
        end else py = y + 1;
      end else px = x + 1;
    endfunction

    function void check_word(out_word_t o);
      update_t e;
      if (pending.size() == 0) begin
        $error("unexpected word: new_value %h last %b", o.new_value, o.last);
        errors++;
        return;
      end
      e = pending.pop_front();
      checked++;
      if (o.last) lasts++;
      if (o.new_value !== e.new_value) begin
        $error("new_value: expected %h actual %h", e.new_value, o.new_value);
        errors++;
      end
      if (o.last !== e.last) begin
        $error("last: expected %b actual %b", e.last, o.last);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  ds3d_if #(.T(in_word_t))  in_ch();
  ds3d_if #(.T(out_word_t)) out_ch();
  ds3d_if #(.T(cfg_word_t)) cfg_ch();

  diffusion_stencil_3d_step dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source),
    .cfg_ch (cfg_ch.sink)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  update_board board = new();
  bit calm;        // no idling on either side
  int voxels_sent;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data = '0;
    out_ch.ready = 1'b0;
  end

  // result sink with random stalls
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_ch.valid && out_ch.ready) board.check_word(out_ch.data);
      out_ch.ready <= calm || ($urandom_range(99) >= 20);
    end
  end

  task automatic cfg_write(cfg_reg_e idx, logic [31:0] d);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data <= '{index: idx, data: d};
    do @(posedge clk_i); while (!cfg_ch.ready);
    board.write_reg(idx, d);
  endtask

  task automatic send_voxel(in_word_t w);
    while (!calm && $urandom_range(99) < 20) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= w;
    do @(posedge clk_i); while (!in_ch.ready);
    board.note_voxel(w);
    voxels_sent++;
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  function automatic logic [31:0] rnd_word();
    case ($urandom_range(5))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return $urandom_range(1, 0) ? 32'h40000000 : 32'hc0000000;
      default: return $urandom;
    endcase
  endfunction

  // moderate values keep most updates off saturation
  function automatic logic [31:0] mild();
    return 32'($signed($urandom_range(1 << 26)) - (1 << 25));
  endfunction

  task automatic run_grid(int unsigned w, int unsigned h, int unsigned d,
                          bit wild, bit directed);
    in_word_t v;
    for (int unsigned k = 0; k < w * h * d; k++) begin
      if (directed) begin
        v.voxel_value   = k[0] ? 32'h7fffffff : 32'h80000000;
        v.corr_factor   = k[1] ? 32'h7fffffff : 32'h80000000;
        v.buffer_factor = k[2] ? 32'h7fffffff : 32'h80000000;
        v.conv_frac     = k[3] ? 32'h7fffffff : 32'h80000000;
      end else if (wild) begin
        v = '{rnd_word(), rnd_word(), rnd_word(), rnd_word()};
      end else begin
        v = '{mild(), mild(), mild(), mild()};
      end
      send_voxel(v);
    end
  endtask

  task automatic set_grid(logic [31:0] a, logic [31:0] b, logic [31:0] c,
                          logic [6:0] w, logic [6:0] h, logic [6:0] d);
    cfg_write(REG_COEFF_X, a);
    cfg_write(REG_COEFF_Y, b);
    cfg_write(REG_COEFF_Z, c);
    cfg_write(REG_GRID_WIDTH, 32'(w));
    cfg_write(REG_GRID_HEIGHT, 32'(h));
    cfg_write(REG_GRID_DEPTH, 32'(d));
    cfg_ch.valid <= 1'b0;
  endtask

  initial begin
    int unsigned gw, gh, gd;
    board.reset_state();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: smallest grid, extreme weights and fields
    set_grid(32'h7fffffff, 32'h80000000, 32'h7fffffff, 7'd3, 7'd3, 7'd2);
    run_grid(3, 3, 2, 0, 1);
    drain();
    // out-of-range sizes saturate to the limits
    set_grid(32'h80000000, 32'h7fffffff, 32'h80000000, 7'd0, 7'd1, 7'd0);
    run_grid(3, 3, 2, 1, 0);
    drain();

    // random grids, one idle-free stretch in the middle
    for (int g = 0; voxels_sent < 630; g++) begin
      calm = (g == 6);
      gw = $urandom_range(3, 6);
      gh = $urandom_range(3, 5);
      gd = $urandom_range(2, 5);
      set_grid($urandom_range(1, 0) ? mild() << 4 : rnd_word(),
               $urandom_range(1, 0) ? mild() << 4 : rnd_word(),
               $urandom_range(1, 0) ? mild() << 4 : rnd_word(),
               7'(gw), 7'(gh), 7'(gd));
      run_grid(gw, gh, gd, $urandom_range(3) == 0, 0);
      drain();
    end
    calm = 0;

    // one full-size row: widest grid, few rows and planes
    set_grid(mild(), mild(), mild(), 7'd64, 7'd3, 7'd2);
    run_grid(64, 3, 2, 0, 0);
    drain();
    // upper limits above range saturate to the maximum
    set_grid(mild(), mild(), mild(), 7'd127, 7'd3, 7'd2);
    run_grid(64, 3, 2, 1, 0);
    drain();

    $display("Covered %0d voxels over many grid sizes and weights.", voxels_sent);
    $display("%0d updates checked, %0d ends of step.", board.checked, board.lasts);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #50ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule
